// ===== hdl/ldss_pkg.sv =====
`default_nettype none

package ldss_pkg;

  // Fixed field widths of the request and response transactions
  localparam int REQ_W    = 2;
  localparam int RANK_W   = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Cell operations, broadcast to every cell of the chain
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_LOAD   = 3'd1;
  localparam logic [2:0] CELL_ROTATE = 3'd2;
  localparam logic [2:0] CELL_SWAP   = 3'd3;
  localparam logic [2:0] CELL_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0] op;     // one of CELL_*
    logic       phase;  // odd/even pairing for the swap pass
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ldss_cell.sv =====
`default_nettype none

// One storage slot of the chain: a value and a live flag.
// Rotate takes the neighbor to the right; swap pulls a live entry
// leftward over a dead one (odd-even transposition on the live flag).
module ldss_cell
  import ldss_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int DEPTH       = 64,
  parameter int IW          = 6,
  parameter int IDX         = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_ctl_t              ctl,
  input  wire logic [IW-1:0]          wr_idx,
  input  wire logic [VALUE_WIDTH-1:0] wr_value,
  input  wire logic [VALUE_WIDTH-1:0] rot_value,
  input  wire logic                   rot_live,
  input  wire logic [VALUE_WIDTH-1:0] lft_value,
  input  wire logic                   lft_live,
  input  wire logic [VALUE_WIDTH-1:0] rgt_value,
  input  wire logic                   rgt_live,
  output logic [VALUE_WIDTH-1:0]      value,
  output logic                        live
);

  localparam logic IDX_ODD = 1'(IDX % 2);

  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   live_r, live_nxt;
  logic                   as_left, as_right;

  // Pair role in the current swap phase
  assign as_left  = (IDX < DEPTH - 1) && (ctl.phase == IDX_ODD);
  assign as_right = (IDX > 0) && (ctl.phase != IDX_ODD);

  always_comb begin
    value_nxt = value_r;
    live_nxt  = live_r;
    case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_LOAD: begin
        if (wr_idx == IW'(IDX)) begin
          value_nxt = wr_value;
          live_nxt  = 1'b1;
        end
      end
      CELL_ROTATE: begin
        value_nxt = rot_value;
        live_nxt  = rot_live;
      end
      CELL_SWAP: begin
        if (as_left && !live_r && rgt_live) begin
          value_nxt = rgt_value;
          live_nxt  = 1'b1;
        end else if (as_right && !lft_live && live_r) begin
          value_nxt = lft_value;
          live_nxt  = 1'b0;
        end
      end
      CELL_CLEAR: begin
        live_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign live  = live_r;

endmodule

`default_nettype wire

// ===== hdl/lazy_delete_sequence_store_unit.sv =====
`default_nettype none

// Ordered store of up to DEPTH values with tombstone deletion, held in a
// ring of DEPTH cells. Append and clear, and any request with rank zero,
// go from acceptance straight to the response state. Read and delete by
// rank rotate the whole ring once past cell 0 while counting live entries;
// a delete that triggers compaction then runs odd-even swap passes. One
// request is in work at a time; a finished response waits in the output
// register while the next request is taken. Reset clears all live flags
// at once, so there is no clearing pass.
module lazy_delete_sequence_store_unit
  import ldss_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [RANK_W-1:0]   in_rank,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [LIVE_W-1:0]        out_live_count,
  output logic                     out_compacted
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SQZ  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CW-1:0]          stored_r, stored_nxt;
  logic [CW-1:0]          marked_r, marked_nxt;
  logic [CW-1:0]          marked_inc;
  logic [IW-1:0]          step_r, step_nxt;
  logic [RANK_W-1:0]      rem_r, rem_nxt;
  logic                   found_r, found_nxt;
  logic                   is_del_r, is_del_nxt;
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [VALUE_WIDTH-1:0] res_data_r, res_data_nxt;
  logic                   res_comp_r, res_comp_nxt;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [VALUE_WIDTH-1:0] out_data_r;
  logic [LIVE_W-1:0]      out_live_r;
  logic                   out_comp_r;

  cell_ctl_t              ctl;
  logic                   kill;
  logic                   hit;
  logic                   last_step;
  logic                   resp_load;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [IW-1:0]          wr_idx;

  logic [VALUE_WIDTH-1:0] cv [DEPTH];
  logic [DEPTH-1:0]       cl;

  assign wr_value   = VALUE_WIDTH'(in_value[VW-1:0]);
  assign wr_idx     = stored_r[IW-1:0];
  assign marked_inc = marked_r + CW'(1);
  assign last_step  = (step_r == IW'(DEPTH - 1));
  assign hit        = (state_r == S_SCAN) && !found_r && cl[0] && (rem_r == RANK_W'(1));
  assign resp_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // Cell ring: rotation runs toward cell 0, cell 0 wraps to the far end
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] rot_v, lft_v, rgt_v;
    logic                   rot_l, lft_l, rgt_l;

    if (g == DEPTH - 1) begin : g_tail
      assign rot_v = cv[0];
      assign rot_l = cl[0] & ~kill;
      assign rgt_v = '0;
      assign rgt_l = 1'b0;
    end else begin : g_body
      assign rot_v = cv[g+1];
      assign rot_l = cl[g+1];
      assign rgt_v = cv[g+1];
      assign rgt_l = cl[g+1];
    end

    if (g == 0) begin : g_head
      assign lft_v = '0;
      assign lft_l = 1'b1;
    end else begin : g_inner
      assign lft_v = cv[g-1];
      assign lft_l = cl[g-1];
    end

    ldss_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DEPTH       (DEPTH),
      .IW          (IW),
      .IDX         (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr_idx    (wr_idx),
      .wr_value  (wr_value),
      .rot_value (rot_v),
      .rot_live  (rot_l),
      .lft_value (lft_v),
      .lft_live  (lft_l),
      .rgt_value (rgt_v),
      .rgt_live  (rgt_l),
      .value     (cv[g]),
      .live      (cl[g])
    );
  end

  // Request sequencer
  always_comb begin
    state_nxt      = state_r;
    stored_nxt     = stored_r;
    marked_nxt     = marked_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    found_nxt      = found_r;
    is_del_nxt     = is_del_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_comp_nxt   = res_comp_r;
    ctl.op         = CELL_HOLD;
    ctl.phase      = step_r[0];
    kill           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          res_comp_nxt   = 1'b0;
          state_nxt      = S_RESP;
          case (in_req_type)
            REQ_APPEND: begin
              if (stored_r == CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ctl.op     = CELL_LOAD;
                stored_nxt = stored_r + CW'(1);
              end
            end
            REQ_DELETE, REQ_READ: begin
              if (in_rank == '0) begin
                res_status_nxt = ST_RANGE;
              end else begin
                state_nxt  = S_SCAN;
                step_nxt   = '0;
                rem_nxt    = in_rank;
                found_nxt  = 1'b0;
                is_del_nxt = (in_req_type == REQ_DELETE);
              end
            end
            REQ_CLEAR: begin
              ctl.op     = CELL_CLEAR;
              stored_nxt = '0;
              marked_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // One full turn of the ring; cell 0 sees entries in order
      S_SCAN: begin
        ctl.op   = CELL_ROTATE;
        step_nxt = step_r + IW'(1);
        if (hit) begin
          found_nxt    = 1'b1;
          res_data_nxt = cv[0];
          kill         = is_del_r;
        end else if (!found_r && cl[0]) begin
          rem_nxt = rem_r - RANK_W'(1);
        end
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = S_RESP;
          if (!(found_r || hit)) begin
            res_status_nxt = ST_RANGE;
          end else if (is_del_r) begin
            marked_nxt = marked_inc;
            if ((stored_r >> 1) <= marked_inc) begin
              state_nxt = S_SQZ;
            end
          end
        end
      end

      // Odd-even swap passes move dead slots to the tail
      S_SQZ: begin
        ctl.op   = CELL_SWAP;
        step_nxt = step_r + IW'(1);
        if (last_step) begin
          step_nxt     = '0;
          stored_nxt   = stored_r - marked_r;
          marked_nxt   = '0;
          res_comp_nxt = 1'b1;
          state_nxt    = S_RESP;
        end
      end

      S_RESP: begin
        if (resp_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      stored_r <= '0;
      marked_r <= '0;
      step_r   <= '0;
      found_r  <= 1'b0;
      is_del_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stored_r <= stored_nxt;
      marked_r <= marked_nxt;
      step_r   <= step_nxt;
      found_r  <= found_nxt;
      is_del_r <= is_del_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_comp_r   <= res_comp_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_live_r   <= LIVE_W'(stored_r - marked_r);
      out_comp_r   <= res_comp_r;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_out   = DATA_W'(out_data_r[VW-1:0]);
  assign out_live_count = out_live_r;
  assign out_compacted  = out_comp_r;

`ifndef SYNTHESIS
  a_marked_le_stored : assert property (@(posedge clk) disable iff (!rst_n)
    marked_r <= stored_r)
    else $error("marked count exceeds stored count");

  a_stored_le_depth : assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CW'(DEPTH))
    else $error("stored count exceeds depth");

  a_sqz_has_marks : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQZ) |-> (marked_r != '0))
    else $error("compaction running with no marked entries");

  a_resp_from_seq : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("response raised outside the response state");

  a_no_kill_on_read : assert property (@(posedge clk) disable iff (!rst_n)
    kill |-> (is_del_r && state_r == S_SCAN))
    else $error("entry marked outside a delete scan");
`endif

endmodule

`default_nettype wire
